>>> src/hbk_pkg.sv
package hbk_pkg;

    // Slot counts and result limits
    localparam int KEY_SLOTS_DEF = 6;
    localparam int IN_SLOTS      = 6;
    localparam int MAX_EVENTS    = 16;
    localparam int MOD_EVENTS    = 4;

    // Target modifier codes
    localparam logic [2:0] MOD_NONE  = 3'd0;
    localparam logic [2:0] MOD_SHIFT = 3'd3;
    localparam logic [2:0] MOD_CTRL  = 3'd4;

    // Modifier event codes
    localparam logic [15:0] CODE_CTRL  = 16'hAA00;
    localparam logic [15:0] CODE_SHIFT = 16'hAB00;
    localparam logic [15:0] CODE_HIGH  = 16'hFF00;

    // Watched modifier bits: left ctrl, right ctrl, left shift, right shift
    localparam logic [7:0] MASK_LCTRL  = 8'h01;
    localparam logic [7:0] MASK_RCTRL  = 8'h10;
    localparam logic [7:0] MASK_LSHIFT = 8'h02;
    localparam logic [7:0] MASK_RSHIFT = 8'h20;

    typedef struct packed {
        logic       transfer_ok;
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_report;

    typedef struct packed {
        logic [15:0] event_code;
        logic        is_release;
        logic [2:0]  modifier_code;
        logic        last_event;
    } t_event;

    // Remap usage IDs for the AZERTY layout
    function automatic logic [7:0] azerty_remap(input logic [7:0] k);
        case (k)
            8'h04:   azerty_remap = 8'h14;
            8'h10:   azerty_remap = 8'h36;
            8'h14:   azerty_remap = 8'h04;
            8'h1A:   azerty_remap = 8'h1D;
            8'h1D:   azerty_remap = 8'h1A;
            8'h33:   azerty_remap = 8'h10;
            8'h36:   azerty_remap = 8'h33;
            default: azerty_remap = k;
        endcase
    endfunction

    // Usage ID to scancode (high byte) and ASCII (low byte)
    function automatic logic [15:0] key_rom(input logic [7:0] k);
        case (k)
            8'h04: key_rom = 16'h6661;  8'h05: key_rom = 16'h4662;
            8'h06: key_rom = 16'h2663;  8'h07: key_rom = 16'h8564;
            8'h08: key_rom = 16'h6565;  8'h09: key_rom = 16'h4566;
            8'h0A: key_rom = 16'h2567;  8'h0B: key_rom = 16'h8468;
            8'h0C: key_rom = 16'h6469;  8'h0D: key_rom = 16'h446A;
            8'h0E: key_rom = 16'h246B;  8'h0F: key_rom = 16'h836C;
            8'h10: key_rom = 16'h636D;  8'h11: key_rom = 16'h436E;
            8'h12: key_rom = 16'h236F;  8'h13: key_rom = 16'h8270;
            8'h14: key_rom = 16'h6271;  8'h15: key_rom = 16'h4272;
            8'h16: key_rom = 16'h2273;  8'h17: key_rom = 16'h8174;
            8'h18: key_rom = 16'h6175;  8'h19: key_rom = 16'h4176;
            8'h1A: key_rom = 16'h2177;  8'h1B: key_rom = 16'h8078;
            8'h1C: key_rom = 16'h6079;  8'h1D: key_rom = 16'h407A;
            8'h28: key_rom = 16'h100D;  8'h29: key_rom = 16'h961B;
            8'h2A: key_rom = 16'h1508;  8'h2B: key_rom = 16'h9509;
            8'h2C: key_rom = 16'h2020;  8'h36: key_rom = 16'hA02C;
            8'h4A: key_rom = 16'hFD00;  8'h4F: key_rom = 16'h2700;
            8'h50: key_rom = 16'h0700;  8'h51: key_rom = 16'h3700;
            8'h52: key_rom = 16'h1700;  8'h54: key_rom = 16'h142F;
            8'h55: key_rom = 16'h132A;  8'h56: key_rom = 16'h122D;
            8'h57: key_rom = 16'h112B;  8'h58: key_rom = 16'h100D;
            8'h59: key_rom = 16'h7331;  8'h5A: key_rom = 16'h5332;
            8'h5B: key_rom = 16'h3333;  8'h5C: key_rom = 16'h7234;
            8'h5D: key_rom = 16'h5235;  8'h5E: key_rom = 16'h3236;
            8'h5F: key_rom = 16'h7037;  8'h60: key_rom = 16'h5138;
            8'h61: key_rom = 16'h3139;  8'h62: key_rom = 16'h5030;
            8'h63: key_rom = 16'h702E;
            default: key_rom = 16'h0000;
        endcase
    endfunction

    // Remap (AZERTY only), look up, and uppercase letters while shift is active
    function automatic logic [15:0] translate(input logic [7:0] k, input logic azerty,
                                              input logic [2:0] active);
        logic [15:0] code;
        logic [7:0]  lo;
        code = key_rom(azerty ? azerty_remap(k) : k);
        lo   = code[7:0];
        if (active == MOD_SHIFT && (lo inside {[8'h61:8'h7A]})) begin
            code = (code & CODE_HIGH) | {8'h00, lo - 8'h20};
        end
        translate = code;
    endfunction

endpackage

>>> src/hbk_lane.sv
module hbk_lane
    import hbk_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  logic [7:0]                 i_key,
    input  logic                       i_key_ok,
    input  logic [KEY_SLOTS-1:0][7:0]  i_list,
    input  logic [KEY_SLOTS-1:0]       i_list_ok,
    output logic                       o_absent
);

    logic [KEY_SLOTS-1:0] w_hit;

    // Compare the key against every live entry of the other list
    always_comb begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
            w_hit[j] = i_list_ok[j] && (i_list[j] == i_key);
        end
    end

    assign o_absent = i_key_ok && !(|w_hit);

endmodule

>>> src/hbk_diff.sv
module hbk_diff
    import hbk_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF,
    parameter int EV_W      = MOD_EVENTS + 2 * KEY_SLOTS
) (
    input  logic [7:0]                 i_mod,
    input  logic [7:0]                 i_prev_mod,
    input  logic [KEY_SLOTS-1:0][7:0]  i_cur,
    input  logic [KEY_SLOTS-1:0][7:0]  i_prev,
    output logic [EV_W-1:0]            o_mask
);

    logic [KEY_SLOTS-1:0] w_cur_ok;
    logic [KEY_SLOTS-1:0] w_prev_ok;
    logic [KEY_SLOTS-1:0] w_rel;
    logic [KEY_SLOTS-1:0] w_prs;
    logic [7:0]           w_chg;

    // Mark slots ahead of the first zero in each list
    always_comb begin
        w_cur_ok[0]  = (i_cur[0] != 8'h00);
        w_prev_ok[0] = (i_prev[0] != 8'h00);
        for (int i = 1; i < KEY_SLOTS; i++) begin
            w_cur_ok[i]  = w_cur_ok[i-1] && (i_cur[i] != 8'h00);
            w_prev_ok[i] = w_prev_ok[i-1] && (i_prev[i] != 8'h00);
        end
    end

    // One lane per slot and direction
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        hbk_lane #(.KEY_SLOTS(KEY_SLOTS)) u_rel (
            .i_key     (i_prev[g]),
            .i_key_ok  (w_prev_ok[g]),
            .i_list    (i_cur),
            .i_list_ok (w_cur_ok),
            .o_absent  (w_rel[g])
        );
        hbk_lane #(.KEY_SLOTS(KEY_SLOTS)) u_prs (
            .i_key     (i_cur[g]),
            .i_key_ok  (w_cur_ok[g]),
            .i_list    (i_prev),
            .i_list_ok (w_prev_ok),
            .o_absent  (w_prs[g])
        );
    end

    // Merge modifier changes, releases and presses in emission order
    assign w_chg  = i_mod ^ i_prev_mod;
    assign o_mask = {w_prs, w_rel,
                     |(w_chg & MASK_RSHIFT), |(w_chg & MASK_LSHIFT),
                     |(w_chg & MASK_RCTRL),  |(w_chg & MASK_LCTRL)};

endmodule

>>> src/hid_boot_keyboard_report_differ.sv
// Boot-keyboard report differ: one report in, up to sixteen key/modifier events out.
// An accepted report queues its events; each event is registered before it is output.
// Throughput: one event per cycle while the event side does not stall; a report with N events
// (0..16) keeps the input stalled until all N have been emitted, since a single serial event
// emitter serves the whole report.
// Reset (synchronous, active low) clears key history, modifiers and layout select.
module hid_boot_keyboard_report_differ
    import hbk_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_report i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_event  o_out_data,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data
);

    localparam int EV_W   = MOD_EVENTS + 2 * KEY_SLOTS;
    localparam int IDX_W  = $clog2(EV_W);
    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_EVENTS);

    logic [KEY_SLOTS-1:0][7:0] r_prev, n_prev;
    logic [KEY_SLOTS-1:0][7:0] r_old;
    logic [7:0]                r_prev_mod;
    logic [MOD_EVENTS-1:0]     r_mod_now;
    logic [2:0]                r_active, n_active;
    logic [EV_W-1:0]           r_mask, n_mask;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_layout;
    logic                      r_out_valid, n_out_valid;
    t_event                    r_out, n_out;

    logic [KEY_SLOTS-1:0][7:0] w_cur;
    logic [IN_SLOTS-1:0][7:0]  w_slots;
    logic [EV_W-1:0]           w_mask;
    logic [EV_W-1:0]           w_rest;
    logic [IDX_W-1:0]          w_idx;
    logic [IDX_W-1:0]          w_off;
    logic [SLOT_W-1:0]         w_slot;
    logic [7:0]                w_key;
    logic                      w_mod_on;
    logic                      w_accept;
    logic                      w_take;
    logic                      w_emit;
    logic                      w_last;

    assign w_slots = {i_in_data.key_slot_5, i_in_data.key_slot_4, i_in_data.key_slot_3,
                      i_in_data.key_slot_2, i_in_data.key_slot_1, i_in_data.key_slot_0};

    // Slots past the input fields read as zero
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_cur[i] = (i < IN_SLOTS) ? w_slots[i] : 8'h00;
        end
    end

    hbk_diff #(.KEY_SLOTS(KEY_SLOTS), .EV_W(EV_W)) u_diff (
        .i_mod      (i_in_data.modifier_bits),
        .i_prev_mod (r_prev_mod),
        .i_cur      (w_cur),
        .i_prev     (r_prev),
        .o_mask     (w_mask)
    );

    assign o_in_stall  = (r_mask != '0);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_take      = w_accept && i_in_data.transfer_ok;
    assign w_emit      = (r_mask != '0) && (!r_out_valid || !i_out_stall);

    // Pick the lowest pending event
    always_comb begin
        w_idx = '0;
        for (int i = EV_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    assign w_rest = r_mask & ~(EV_W'(1) << w_idx);
    assign w_last = (w_rest == '0) || (r_cnt == CNT_W'(MAX_EVENTS - 1));

    // Locate the key slot behind a release or press event
    always_comb begin
        if (w_idx < IDX_W'(MOD_EVENTS + KEY_SLOTS)) begin
            w_off = w_idx - IDX_W'(MOD_EVENTS);
        end else begin
            w_off = w_idx - IDX_W'(MOD_EVENTS + KEY_SLOTS);
        end
        w_slot = w_off[SLOT_W-1:0];
        w_key  = (w_idx < IDX_W'(MOD_EVENTS + KEY_SLOTS)) ? r_old[w_slot] : r_prev[w_slot];
    end

    // Build the next event and advance the pending set
    always_comb begin
        n_prev      = r_prev;
        n_active    = r_active;
        n_mask      = r_mask;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_mod_on    = r_mod_now[w_idx[1:0]];
        if (w_take) begin
            n_prev = w_cur;
            n_mask = w_mask;
            n_cnt  = '0;
        end
        if (w_emit) begin
            n_out_valid          = 1'b1;
            n_mask               = w_last ? '0 : w_rest;
            n_cnt                = r_cnt + CNT_W'(1);
            n_out.last_event     = w_last;
            if (w_idx < IDX_W'(MOD_EVENTS)) begin
                if (w_idx < IDX_W'(2)) begin
                    n_out.event_code = CODE_CTRL;
                    n_active         = w_mod_on ? MOD_CTRL : MOD_NONE;
                end else begin
                    n_out.event_code = CODE_SHIFT;
                    n_active         = w_mod_on ? MOD_SHIFT : MOD_NONE;
                end
                n_out.is_release = !w_mod_on;
            end else begin
                n_out.event_code = translate(w_key, r_layout, r_active);
                n_out.is_release = (w_idx < IDX_W'(MOD_EVENTS + KEY_SLOTS));
            end
            n_out.modifier_code = n_active;
        end
    end

    // Hold state, output valid and layout select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_prev_mod  <= '0;
            r_active    <= MOD_NONE;
            r_mask      <= '0;
            r_cnt       <= '0;
            r_layout    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_active    <= n_active;
            r_mask      <= n_mask;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_prev_mod <= i_in_data.modifier_bits;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_layout <= i_cfg_data;
            end
        end
    end

    // Register the output event; snapshot the old list and watched modifier levels for the emitter
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_take) begin
            r_old     <= r_prev;
            r_mod_now <= {|(i_in_data.modifier_bits & MASK_RSHIFT),
                          |(i_in_data.modifier_bits & MASK_LSHIFT),
                          |(i_in_data.modifier_bits & MASK_RCTRL),
                          |(i_in_data.modifier_bits & MASK_LCTRL)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
